>>> rtl/mcht_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the key byte-sum function of the MAC-keyed
// chained hash table. No dependencies; used by every other file.

package mcht_pkg;

  localparam int BUCKET_SLOTS_DEF = 64;
  localparam int POOL_ENTRIES_DEF = 256;

  localparam int KEY_BYTES = 6;
  localparam int KEY_W     = 48;
  localparam int VAL_W     = 32;
  localparam int CFG_W     = 7;
  localparam int SUM_W     = 11;
  localparam int STATUS_W  = 2;

  localparam logic [CFG_W-1:0] BUCKET_COUNT_RESET = 7'd64;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_SEARCH = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_INSERTED = 2'd0,
    STATUS_FULL     = 2'd1,
    STATUS_HIT      = 2'd2,
    STATUS_MISS     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    FSM_CLEAR,
    FSM_IDLE,
    FSM_HASH,
    FSM_HEAD,
    FSM_ENTRY
  } fsm_t;

  function automatic logic [SUM_W-1:0] byte_sum(input logic [KEY_W-1:0] key);
    logic [SUM_W-1:0] acc;
    acc = '0;
    for (int i = 0; i < KEY_BYTES; i++) begin
      acc = acc + SUM_W'(key[8*i +: 8]);
    end
    return acc;
  endfunction

endpackage

>>> rtl/mac_chained_hash_table_top.sv
`timescale 1ns / 1ps
// Top level of the MAC-keyed chained hash table: sequencer, bucket heads and entry pool.
// Depends on mcht_pkg and mcht_mod_unit.

// A transaction is accepted when start is high and busy is low. The bucket index
// is found by a bit-serial remainder unit, so an insert or a search of an empty
// bucket keeps busy high through the hash and head states, and its result appears
// in the cycle where busy falls; a search stays in the entry state for every chain
// entry it examines, since the entry pool is read once per cycle.
// The result is shown for exactly one cycle with done high and cannot be held
// off. After reset the bucket heads are cleared one per cycle, which keeps busy
// high until every bucket head is clear; configuration writes are taken at any time.

module mac_chained_hash_table_top #(
  parameter int BUCKET_SLOTS = mcht_pkg::BUCKET_SLOTS_DEF,
  parameter int POOL_ENTRIES = mcht_pkg::POOL_ENTRIES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [mcht_pkg::CFG_W-1:0]     cfg_wr_data,
  input  logic                           start,
  output logic                           busy,
  input  logic                           req_type,
  input  logic [mcht_pkg::KEY_W-1:0]     mac_key,
  input  logic [mcht_pkg::VAL_W-1:0]     item_value,
  output logic                           done,
  output logic [mcht_pkg::STATUS_W-1:0]  status,
  output logic [mcht_pkg::VAL_W-1:0]     found_value
);

  localparam int BK_W    = (BUCKET_SLOTS > 1) ? $clog2(BUCKET_SLOTS) : 1;
  localparam int IDX_W   = $clog2(POOL_ENTRIES);
  localparam int CNT_W   = IDX_W + 1;
  localparam int LINK_W  = IDX_W + 1;
  localparam int ENTRY_W = mcht_pkg::KEY_W + mcht_pkg::VAL_W + LINK_W;

  mcht_pkg::fsm_t state;
  mcht_pkg::fsm_t state_next;

  logic [mcht_pkg::CFG_W-1:0] bucket_count;
  logic [mcht_pkg::CFG_W-1:0] modulus;
  logic [BK_W-1:0]            clr_addr;
  logic [CNT_W-1:0]           entries_used;

  logic                       req_q;
  logic [mcht_pkg::KEY_W-1:0] key_q;
  logic [mcht_pkg::VAL_W-1:0] val_q;

  logic                       accept;
  logic                       mod_done;
  logic [mcht_pkg::CFG_W-1:0] mod_rem;
  logic [31:0]                rem_ext;
  logic [BK_W-1:0]            bucket;

  logic [LINK_W-1:0]  heads [BUCKET_SLOTS];
  logic [ENTRY_W-1:0] entries [POOL_ENTRIES];
  logic [LINK_W-1:0]  head_rd;
  logic [ENTRY_W-1:0] entry_rd;
  logic [IDX_W-1:0]   entry_raddr;

  logic                       pool_full;
  logic                       key_match;
  logic                       head_we;
  logic                       entry_we;
  logic                       res_valid;
  mcht_pkg::status_t          res_status;
  logic [mcht_pkg::VAL_W-1:0] res_value;

  assign busy      = (state != mcht_pkg::FSM_IDLE);
  assign accept    = start && (state == mcht_pkg::FSM_IDLE);
  assign pool_full = (entries_used == CNT_W'(POOL_ENTRIES));
  assign key_match = (entry_rd[ENTRY_W-1 -: mcht_pkg::KEY_W] == key_q);
  assign rem_ext   = 32'(mod_rem);
  assign bucket    = rem_ext[BK_W-1:0];

  always_comb begin
    if (bucket_count == '0) begin
      modulus = mcht_pkg::CFG_W'(1);
    end else if (32'(bucket_count) > BUCKET_SLOTS) begin
      modulus = mcht_pkg::CFG_W'(BUCKET_SLOTS);
    end else begin
      modulus = bucket_count;
    end
  end

  mcht_mod_unit u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (accept),
    .dividend  (mcht_pkg::byte_sum(mac_key)),
    .modulus   (modulus),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_count <= mcht_pkg::BUCKET_COUNT_RESET;
    end else if (cfg_wr_en) begin
      bucket_count <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= mcht_pkg::FSM_CLEAR;
      clr_addr     <= '0;
      entries_used <= '0;
      done         <= 1'b0;
    end else begin
      state <= state_next;
      done  <= res_valid;
      if (state == mcht_pkg::FSM_CLEAR) begin
        clr_addr <= clr_addr + BK_W'(1);
      end
      if (entry_we) begin
        entries_used <= entries_used + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    status      <= res_status;
    found_value <= res_value;
    if (accept) begin
      req_q <= req_type;
      key_q <= mac_key;
      val_q <= item_value;
    end
  end

  always_ff @(posedge clk) begin
    if (state == mcht_pkg::FSM_CLEAR) begin
      heads[clr_addr] <= '0;
    end else if (head_we) begin
      heads[bucket] <= {1'b1, entries_used[IDX_W-1:0]};
    end
    head_rd <= heads[bucket];
  end

  always_ff @(posedge clk) begin
    if (entry_we) begin
      entries[entries_used[IDX_W-1:0]] <= {key_q, val_q, head_rd};
    end
    entry_rd <= entries[entry_raddr];
  end

  always_comb begin
    state_next  = state;
    res_valid   = 1'b0;
    res_status  = mcht_pkg::STATUS_MISS;
    res_value   = '0;
    head_we     = 1'b0;
    entry_we    = 1'b0;
    entry_raddr = entry_rd[IDX_W-1:0];
    case (state)
      mcht_pkg::FSM_CLEAR: begin
        if (clr_addr == BK_W'(BUCKET_SLOTS - 1)) begin
          state_next = mcht_pkg::FSM_IDLE;
        end
      end
      mcht_pkg::FSM_IDLE: begin
        if (start) begin
          state_next = mcht_pkg::FSM_HASH;
        end
      end
      mcht_pkg::FSM_HASH: begin
        if (mod_done) begin
          state_next = mcht_pkg::FSM_HEAD;
        end
      end
      mcht_pkg::FSM_HEAD: begin
        if (req_q == mcht_pkg::REQ_INSERT) begin
          res_valid  = 1'b1;
          state_next = mcht_pkg::FSM_IDLE;
          if (pool_full) begin
            res_status = mcht_pkg::STATUS_FULL;
          end else begin
            res_status = mcht_pkg::STATUS_INSERTED;
            head_we    = 1'b1;
            entry_we   = 1'b1;
          end
        end else if (head_rd[LINK_W-1]) begin
          entry_raddr = head_rd[IDX_W-1:0];
          state_next  = mcht_pkg::FSM_ENTRY;
        end else begin
          res_valid  = 1'b1;
          state_next = mcht_pkg::FSM_IDLE;
        end
      end
      mcht_pkg::FSM_ENTRY: begin
        if (key_match) begin
          res_valid  = 1'b1;
          res_status = mcht_pkg::STATUS_HIT;
          res_value  = entry_rd[LINK_W +: mcht_pkg::VAL_W];
          state_next = mcht_pkg::FSM_IDLE;
        end else if (!entry_rd[LINK_W-1]) begin
          res_valid  = 1'b1;
          state_next = mcht_pkg::FSM_IDLE;
        end
      end
      default: begin
        state_next = mcht_pkg::FSM_CLEAR;
      end
    endcase
  end

endmodule

>>> rtl/mcht_mod_unit.sv
`timescale 1ns / 1ps
// Bit-serial restoring remainder unit: one shared compare and subtract per cycle.
// Depends on mcht_pkg.

module mcht_mod_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [mcht_pkg::SUM_W-1:0]  dividend,
  input  logic [mcht_pkg::CFG_W-1:0]  modulus,
  output logic                        done,
  output logic [mcht_pkg::CFG_W-1:0]  remainder
);

  localparam int STEP_W = $clog2(mcht_pkg::SUM_W);

  logic                        running;
  logic [STEP_W-1:0]           step;
  logic [mcht_pkg::SUM_W-1:0]  shreg;
  logic [mcht_pkg::CFG_W-1:0]  modq;
  logic [mcht_pkg::CFG_W:0]    rem_sh;
  logic [mcht_pkg::CFG_W:0]    mod_ext;
  logic [mcht_pkg::CFG_W-1:0]  rem_next;
  logic                        last_step;

  assign rem_sh    = {remainder, shreg[mcht_pkg::SUM_W-1]};
  assign mod_ext   = {1'b0, modq};
  assign last_step = (step == STEP_W'(mcht_pkg::SUM_W - 1));

  always_comb begin
    if (rem_sh >= mod_ext) begin
      rem_next = mcht_pkg::CFG_W'(rem_sh - mod_ext);
    end else begin
      rem_next = rem_sh[mcht_pkg::CFG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      step    <= '0;
    end else begin
      done <= running && last_step;
      if (start) begin
        running <= 1'b1;
        step    <= '0;
      end else if (running) begin
        step <= step + STEP_W'(1);
        if (last_step) begin
          running <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg     <= dividend;
      modq      <= modulus;
      remainder <= '0;
    end else if (running) begin
      shreg     <= {shreg[mcht_pkg::SUM_W-2:0], 1'b0};
      remainder <= rem_next;
    end
  end

endmodule

>>> rtl/mcht_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the MAC-keyed chained hash table, bound to the top level.
// Depends on mcht_pkg and mac_chained_hash_table_top.

module mcht_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           start,
  input logic                           busy,
  input logic                           done,
  input logic [mcht_pkg::STATUS_W-1:0]  status,
  input logic [mcht_pkg::VAL_W-1:0]     found_value
);

  a_busy_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> busy)
    else $error("busy is low right after reset although the head clear is running");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("an accepted transaction did not raise busy");

  a_no_done_after_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> !done)
    else $error("a result appeared in the cycle after acceptance");

  a_done_from_work: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("a result appeared without a transaction in progress");

  a_value_only_on_hit: assert property (@(posedge clk) disable iff (rst)
    (done && (status != mcht_pkg::STATUS_HIT)) |-> (found_value == '0))
    else $error("found_value is nonzero on a result that is not a search hit");

endmodule

bind mac_chained_hash_table_top mcht_checker u_mcht_checker (.*);

>>> verif/mac_chained_hash_table_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the MAC-keyed chained hash table. It drives bucket-count writes,
// insert and search transactions, predicts the status and value of each one, and checks every result.
// Depends on mcht_pkg and mac_chained_hash_table_top.

module mac_chained_hash_table_top_tb;

  localparam int HEADS = mcht_pkg::BUCKET_SLOTS_DEF;
  localparam int POOL = mcht_pkg::POOL_ENTRIES_DEF;
  localparam int ITEMS_PER_PHASE = 115;
  localparam int PHASES = 10;
  localparam int CYCLE_LIMIT = 2_000_000;

  class lookup_scoreboard;
    logic [mcht_pkg::CFG_W-1:0] bucket_reg;
    int unsigned taken;
    bit head_ok[HEADS];
    int unsigned head_at[HEADS];
    logic [mcht_pkg::KEY_W-1:0] pool_key[POOL];
    logic [mcht_pkg::VAL_W-1:0] pool_val[POOL];
    bit link_ok[POOL];
    int unsigned link_at[POOL];
    mcht_pkg::status_t want_status[$];
    logic [mcht_pkg::VAL_W-1:0] want_value[$];
    int errors;
    int tally[4];

    function new();
      bucket_reg = mcht_pkg::BUCKET_COUNT_RESET;
      taken = 0;
      errors = 0;
      foreach (head_ok[i]) head_ok[i] = 1'b0;
      foreach (tally[i]) tally[i] = 0;
    endfunction

    function void set_buckets(logic [mcht_pkg::CFG_W-1:0] v);
      bucket_reg = v;
    endfunction

    function int unsigned bucket_for(logic [mcht_pkg::KEY_W-1:0] key);
      int unsigned sum;
      int unsigned m;
      sum = 0;
      for (int b = 0; b < mcht_pkg::KEY_BYTES; b++) sum += key[8*b +: 8];
      m = (bucket_reg == 0) ? 1 : ((bucket_reg > HEADS) ? HEADS : bucket_reg);
      return sum % m;
    endfunction

    function void note_request(logic kind, logic [mcht_pkg::KEY_W-1:0] key,
                               logic [mcht_pkg::VAL_W-1:0] val);
      int unsigned bk;
      int unsigned e;
      int unsigned steps;
      bit walking;
      mcht_pkg::status_t st;
      logic [mcht_pkg::VAL_W-1:0] found;
      bk = bucket_for(key);
      found = '0;
      if (kind == mcht_pkg::REQ_INSERT) begin
        if (taken >= POOL) begin
          st = mcht_pkg::STATUS_FULL;
        end else begin
          pool_key[taken] = key;
          pool_val[taken] = val;
          link_ok[taken] = head_ok[bk];
          link_at[taken] = head_at[bk];
          head_ok[bk] = 1'b1;
          head_at[bk] = taken;
          taken++;
          st = mcht_pkg::STATUS_INSERTED;
        end
      end else begin
        st = mcht_pkg::STATUS_MISS;
        walking = head_ok[bk];
        e = head_at[bk];
        steps = 0;
        while (walking && steps < POOL) begin
          if (pool_key[e] == key) begin
            st = mcht_pkg::STATUS_HIT;
            found = pool_val[e];
            walking = 1'b0;
          end else begin
            walking = link_ok[e];
            e = link_at[e];
            steps++;
          end
        end
      end
      want_status.push_back(st);
      want_value.push_back(found);
      tally[st]++;
    endfunction

    task report(string what);
      $display("mismatch at %0t ns: %s", $time, what);
      errors++;
    endtask

    task check_result(logic [mcht_pkg::STATUS_W-1:0] got_status,
                      logic [mcht_pkg::VAL_W-1:0] got_value);
      mcht_pkg::status_t st;
      logic [mcht_pkg::VAL_W-1:0] v;
      if (want_status.size() == 0) begin
        report($sformatf("result with no transaction pending, status %0d", got_status));
        return;
      end
      st = want_status.pop_front();
      v = want_value.pop_front();
      if (got_status !== st)
        report($sformatf("status %0d, expected %s", got_status, st.name()));
      if (got_value !== v)
        report($sformatf("found_value %h, expected %h", got_value, v));
    endtask

    function int pending();
      return want_status.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [mcht_pkg::CFG_W-1:0] cfg_wr_data = '0;
  logic start = 1'b0;
  logic busy;
  logic req_type = mcht_pkg::REQ_INSERT;
  logic [mcht_pkg::KEY_W-1:0] mac_key = '0;
  logic [mcht_pkg::VAL_W-1:0] item_value = '0;
  logic done;
  logic [mcht_pkg::STATUS_W-1:0] status;
  logic [mcht_pkg::VAL_W-1:0] found_value;

  lookup_scoreboard sb;
  logic [mcht_pkg::KEY_W-1:0] known[$];
  logic [mcht_pkg::CFG_W-1:0] plan[PHASES] = '{7'd3, 7'd1, 7'd127, 7'd0, 7'd64, 7'd65, 7'd33,
                                               7'd2, 7'd17, 7'd0};
  int unsigned cycles = 0;
  int settings = 0;

  mac_chained_hash_table_top i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .start      (start),
    .busy       (busy),
    .req_type   (req_type),
    .mac_key    (mac_key),
    .item_value (item_value),
    .done       (done),
    .status     (status),
    .found_value(found_value)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[mac_chained_hash_table_top] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && done !== 1'b0) sb.check_result(status, found_value);
  end

  task automatic issue(logic kind, logic [mcht_pkg::KEY_W-1:0] key,
                       logic [mcht_pkg::VAL_W-1:0] val);
    start <= 1'b1;
    req_type <= kind;
    mac_key <= key;
    item_value <= val;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_request(kind, key, val);
    if (kind == mcht_pkg::REQ_INSERT) known.push_back(key);
  endtask

  task automatic pause(int unsigned n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic wait_idle();
    pause(1);
    while (sb.pending() != 0 || busy !== 1'b0) @(posedge clk);
  endtask

  task automatic write_buckets(logic [mcht_pkg::CFG_W-1:0] v);
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    sb.set_buckets(v);
    cfg_wr_en <= 1'b0;
    settings++;
  endtask

  function automatic logic [mcht_pkg::KEY_W-1:0] any_key();
    logic [mcht_pkg::KEY_W-1:0] k;
    k = mcht_pkg::KEY_W'({$urandom(), $urandom()});
    // Narrow bytes give small sums, so the keys crowd into a few long chains.
    if ($urandom_range(0, 3) == 0)
      for (int b = 0; b < mcht_pkg::KEY_BYTES; b++) k[8*b +: 8] = 8'($urandom_range(0, 3));
    return k;
  endfunction

  function automatic logic [mcht_pkg::KEY_W-1:0] pick_known();
    return known[$urandom_range(0, known.size() - 1)];
  endfunction

  // A key with the same byte sum, so it lands in the same bucket; it can equal k when the two bytes it swaps are equal.
  function automatic logic [mcht_pkg::KEY_W-1:0] same_sum(logic [mcht_pkg::KEY_W-1:0] k);
    logic [mcht_pkg::KEY_W-1:0] r;
    int i;
    int j;
    r = k;
    i = $urandom_range(0, mcht_pkg::KEY_BYTES - 1);
    j = (i + $urandom_range(1, mcht_pkg::KEY_BYTES - 1)) % mcht_pkg::KEY_BYTES;
    if (k[8*i +: 8] != 8'h00 && k[8*j +: 8] != 8'hff) begin
      r[8*i +: 8] = k[8*i +: 8] - 8'd1;
      r[8*j +: 8] = k[8*j +: 8] + 8'd1;
    end else begin
      r[8*i +: 8] = k[8*j +: 8];
      r[8*j +: 8] = k[8*i +: 8];
    end
    return r;
  endfunction

  task automatic random_item();
    logic kind;
    logic [mcht_pkg::KEY_W-1:0] key;
    int unsigned pick;
    kind = ($urandom_range(0, 99) < 35) ? mcht_pkg::REQ_INSERT : mcht_pkg::REQ_SEARCH;
    pick = $urandom_range(0, 9);
    if (known.size() == 0 || (kind == mcht_pkg::REQ_INSERT ? pick < 4 : pick >= 8))
      key = any_key();
    else if (kind == mcht_pkg::REQ_INSERT ? pick < 7 : pick < 6)
      key = pick_known();
    else
      key = same_sum(pick_known());
    issue(kind, key, $urandom());
  endtask

  initial begin
    int unsigned sent;
    int unsigned burst;
    bit quiet;
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    issue(mcht_pkg::REQ_SEARCH, '0, 32'hffff_ffff);
    issue(mcht_pkg::REQ_INSERT, '0, '0);
    issue(mcht_pkg::REQ_INSERT, '1, '1);
    issue(mcht_pkg::REQ_SEARCH, '0, '0);
    issue(mcht_pkg::REQ_SEARCH, '1, '0);
    issue(mcht_pkg::REQ_INSERT, '1, 32'h1234_5678);
    issue(mcht_pkg::REQ_SEARCH, '1, 32'hdead_beef);
    issue(mcht_pkg::REQ_INSERT, 48'h0100_0000_0000, 32'h0000_00a5);
    issue(mcht_pkg::REQ_INSERT, 48'h0000_0000_0001, 32'h0000_005a);
    issue(mcht_pkg::REQ_SEARCH, 48'h0100_0000_0000, '0);
    issue(mcht_pkg::REQ_SEARCH, 48'h0000_0000_0001, '0);
    issue(mcht_pkg::REQ_SEARCH, 48'h0001_0000_0000, '0);
    write_buckets(7'd0);
    issue(mcht_pkg::REQ_SEARCH, '1, '0);
    issue(mcht_pkg::REQ_SEARCH, '0, '0);
    issue(mcht_pkg::REQ_INSERT, 48'h8040_2010_0804, 32'h8000_0001);
    issue(mcht_pkg::REQ_SEARCH, 48'h8040_2010_0804, '0);
    write_buckets(7'd127);
    issue(mcht_pkg::REQ_SEARCH, 48'h8040_2010_0804, '0);
    issue(mcht_pkg::REQ_SEARCH, '1, '0);
    issue(mcht_pkg::REQ_INSERT, 48'h0000_0000_0040, 32'h7fff_ffff);
    issue(mcht_pkg::REQ_SEARCH, 48'h0000_0000_0040, '0);

    for (int p = 0; p < PHASES; p++) begin
      write_buckets(p == PHASES - 1 ? mcht_pkg::CFG_W'($urandom_range(0, 127)) : plan[p]);
      quiet = (p % 3 == 0);
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        burst = $urandom_range(1, 12);
        for (int k = 0; k < burst && sent < ITEMS_PER_PHASE; k++) begin
          random_item();
          sent++;
        end
        if (!quiet && $urandom_range(0, 2) != 0) pause($urandom_range(1, 15));
      end
    end

    wait_idle();
    repeat (20) @(posedge clk);
    $display("Covered %0d bucket-count writes, %0d inserts and %0d inserts refused by a full pool,",
             settings, sb.tally[mcht_pkg::STATUS_INSERTED], sb.tally[mcht_pkg::STATUS_FULL]);
    $display("%0d searches that hit and %0d that missed.",
             sb.tally[mcht_pkg::STATUS_HIT], sb.tally[mcht_pkg::STATUS_MISS]);
    if (sb.errors == 0)
      $display("[mac_chained_hash_table_top] OK");
    else
      $display("[mac_chained_hash_table_top] ERROR");
    $finish;
  end

endmodule
